[rtl/lfk_pkg.sv]
// Package for the leg forward kinematics block: widths, sine coefficients and helpers.
// Depends on nothing; used by every module under rtl.
`default_nettype none
package lfk_pkg;
    localparam int ANGLE_BITS  = 16;
    localparam int LENGTH_BITS = 16;
    localparam int PHASE_BITS  = 24;
    localparam int Q_BITS      = 22;
    localparam int POS_BITS    = 19;
    localparam int ROT_BITS    = 16;
    localparam int ADDR_BITS   = 4;

    localparam logic [30:0] K1 = 31'd1686629713;
    localparam logic [30:0] K3 = 31'd693598667;
    localparam logic [30:0] K5 = 31'd85569306;
    localparam logic [30:0] K7 = 31'd5026995;
    localparam logic [30:0] K9 = 31'd172272;

    localparam logic [ADDR_BITS-1:0] ADDR_HIP      = 4'd0;
    localparam logic [ADDR_BITS-1:0] ADDR_SHOULDER = 4'd4;
    localparam logic [ADDR_BITS-1:0] ADDR_LOWER    = 4'd8;

    localparam int SIN_STAGES = 7;

    // One step of the Horner chain: coefficient minus truncated product.
    function automatic logic [30:0] horner(input logic [30:0] k, input logic [30:0] p,
                                           input logic [22:0] t2);
        logic [53:0] prod;
        prod = p * t2;
        horner = k - prod[52:22];
    endfunction
endpackage
`default_nettype wire

[rtl/lfk_sine_cell.sv]
// One cell of the sine pipeline: carries the argument and works the step set by stage.
// Depends on lfk_pkg.
`default_nettype none
module lfk_sine_cell
    import lfk_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [2:0]        stage,
    input  wire logic [22:0]       t_in,
    input  wire logic [22:0]       t2_in,
    input  wire logic [30:0]       p_in,
    input  wire logic              neg_in,
    output logic      [22:0]       t_out,
    output logic      [22:0]       t2_out,
    output logic      [30:0]       p_out,
    output logic                   neg_out
);
    logic [45:0] sq;
    logic [30:0] p_next;
    logic [53:0] fin;
    logic [16:0] r;

    always_comb
    begin
        sq = t_in * t_in;
        fin = t_in * p_in + 54'(64'd1 << 37);
        r = (fin[53:38] > 16'd16384) ? 17'd16384 : {1'b0, fin[53:38]};
        case (stage)
            3'd0:    p_next = K9;
            3'd1:    p_next = horner(K7, p_in, t2_in);
            3'd2:    p_next = horner(K5, p_in, t2_in);
            3'd3:    p_next = horner(K3, p_in, t2_in);
            3'd4:    p_next = horner(K1, p_in, t2_in);
            3'd5:    p_next = neg_in ? 31'(-$signed({14'd0, r})) : {14'd0, r};
            default: p_next = p_in;
        endcase
    end

    always_ff @(posedge clk)
    begin
        t_out   <= t_in;
        t2_out  <= (stage == 3'd0) ? sq[44:22] : t2_in;
        p_out   <= p_next;
        neg_out <= neg_in;
    end
endmodule
`default_nettype wire

[rtl/lfk_sine.sv]
// Sine pipeline built as a chain of SIN_STAGES registered cells; sine is the last cell's output.
// Depends on lfk_pkg and lfk_sine_cell.
`default_nettype none
module lfk_sine
    import lfk_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic [PHASE_BITS-1:0]  phase,
    output logic signed [16:0]          sine
);
    logic [22:0] t    [0:SIN_STAGES];
    logic [22:0] t2   [0:SIN_STAGES];
    logic [30:0] p    [0:SIN_STAGES];
    logic        neg  [0:SIN_STAGES];
    logic [21:0] f;

    assign f = phase[21:0];
    assign t[0]   = phase[22] ? (23'd4194304 - {1'b0, f}) : {1'b0, f};
    assign t2[0]  = '0;
    assign p[0]   = '0;
    assign neg[0] = phase[23];

    for (genvar i = 0; i < SIN_STAGES; i++)
    begin : g_cell
        lfk_sine_cell u_cell (
            .clk(clk), .stage(3'(i)),
            .t_in(t[i]), .t2_in(t2[i]), .p_in(p[i]), .neg_in(neg[i]),
            .t_out(t[i+1]), .t2_out(t2[i+1]), .p_out(p[i+1]), .neg_out(neg[i+1])
        );
    end

    assign sine = $signed(p[SIN_STAGES][16:0]);
endmodule
`default_nettype wire

[rtl/leg_forward_kinematics.sv]
// Top level of the leg forward kinematics block: register port, sine pipelines, products.
// Depends on lfk_pkg and lfk_sine.
//
// Usage: drive hip_angle, shoulder_angle and knee_angle with start high; a transfer is
// taken at every edge where start is high, and busy is always low, so one leg may be
// presented in every cycle. Each result appears on the rot_* and foot_* ports for one
// cycle with done high, after its transfer has passed the SIN_STAGES sine cells and
// four multiply stages for rotation and position. Throughput is one item per cycle,
// set by the fully pipelined sine cells and multipliers. The link lengths are written
// through the APB-style port at byte addresses 0, 4, 8; the user must do so only while
// the block is idle, which the block itself does not enforce. Reset clears the lengths
// and the valid pipeline; the receiver cannot stall, so results are never held back.
`default_nettype none
module leg_forward_kinematics
    import lfk_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ADDR_BITS-1:0]          paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [ANGLE_BITS-1:0]  hip_angle,
    input  wire logic signed [ANGLE_BITS-1:0]  shoulder_angle,
    input  wire logic signed [ANGLE_BITS-1:0]  knee_angle,
    output logic                               done,
    output logic signed [ROT_BITS-1:0]         rot_00,
    output logic signed [ROT_BITS-1:0]         rot_01,
    output logic signed [ROT_BITS-1:0]         rot_02,
    output logic signed [ROT_BITS-1:0]         rot_10,
    output logic signed [ROT_BITS-1:0]         rot_11,
    output logic signed [ROT_BITS-1:0]         rot_12,
    output logic signed [ROT_BITS-1:0]         rot_20,
    output logic signed [ROT_BITS-1:0]         rot_21,
    output logic signed [ROT_BITS-1:0]         rot_22,
    output logic signed [POS_BITS-1:0]         foot_x,
    output logic signed [POS_BITS-1:0]         foot_y,
    output logic signed [POS_BITS-1:0]         foot_z
);
    localparam int LAT = SIN_STAGES + 4;
    localparam int SH  = PHASE_BITS - ANGLE_BITS;

    logic [LENGTH_BITS-1:0] hip_reg, sho_reg, low_reg;
    logic [LAT-1:0]         vld_reg;
    logic                   wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hip_reg <= '0;
            sho_reg <= '0;
            low_reg <= '0;
            vld_reg <= '0;
        end
        else
        begin
            if (wr && paddr == ADDR_HIP)      hip_reg <= pwdata[LENGTH_BITS-1:0];
            if (wr && paddr == ADDR_SHOULDER) sho_reg <= pwdata[LENGTH_BITS-1:0];
            if (wr && paddr == ADDR_LOWER)    low_reg <= pwdata[LENGTH_BITS-1:0];
            vld_reg <= {vld_reg[LAT-2:0], start};
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_HIP:      prdata = 32'(hip_reg);
            ADDR_SHOULDER: prdata = 32'(sho_reg);
            ADDR_LOWER:    prdata = 32'(low_reg);
            default:       prdata = '0;
        endcase
    end

    // Phases: hip, shoulder, shoulder plus knee, each with cosine a quarter turn ahead.
    logic [ANGLE_BITS-1:0] sum_ang;
    logic [PHASE_BITS-1:0] ph [0:5];
    logic signed [16:0]    sv [0:5];
    localparam logic [PHASE_BITS-1:0] QTR = PHASE_BITS'(1) << Q_BITS;

    assign sum_ang = shoulder_angle + knee_angle;
    assign ph[0] = {hip_angle, SH'(0)};
    assign ph[1] = ph[0] + QTR;
    assign ph[2] = {shoulder_angle, SH'(0)};
    assign ph[3] = ph[2] + QTR;
    assign ph[4] = {sum_ang, SH'(0)};
    assign ph[5] = ph[4] + QTR;

    for (genvar k = 0; k < 6; k++)
    begin : g_sin
        lfk_sine u_sine (.clk(clk), .phase(ph[k]), .sine(sv[k]));
    end

    // Stage A: rotation products and length products.
    logic signed [16:0] sa_a, ca_a, s2_a, c2_a;
    logic signed [33:0] p00_a, p01_a, p10_a, p11_a;
    logic signed [34:0] qx_a, qy_a, hc_a, hs_a;
    // Stage B onwards.
    logic signed [16:0] sa_b, ca_b, s2_b, c2_b;
    logic signed [15:0] r00_b, r01_b, r10_b, r11_b;
    logic signed [34:0] qx_b, qy_b, hc_b, hs_b;
    logic signed [52:0] x1_c, y1_c;
    logic signed [34:0] hc_c, hs_c, qy_c;
    logic signed [53:0] x_d, y_d;
    logic signed [34:0] qy_d;
    logic signed [15:0] r00_c, r01_c, r10_c, r11_c, r00_d, r01_d, r10_d, r11_d;
    logic signed [16:0] sa_c, ca_c, s2_c, c2_c, sa_d, ca_d, s2_d, c2_d;

    function automatic logic signed [15:0] rq14(input logic signed [33:0] v);
        logic signed [33:0] u;
        u = v + 34'sd8192;
        return u[29:14];
    endfunction

    function automatic logic signed [POS_BITS-1:0] satp(input logic signed [53:0] v);
        if (v < -54'sd196608)     return POS_BITS'(-196608);
        else if (v > 54'sd196607) return POS_BITS'(196607);
        else                      return v[POS_BITS-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        sa_a  <= sv[0]; ca_a <= sv[1]; s2_a <= sv[4]; c2_a <= sv[5];
        p00_a <= sv[0] * sv[5];
        p01_a <= -(sv[0] * sv[4]);
        p10_a <= -(sv[1] * sv[5]);
        p11_a <= sv[1] * sv[4];
        qx_a  <= $signed({1'b0, sho_reg}) * sv[3] + $signed({1'b0, low_reg}) * sv[5];
        qy_a  <= $signed({1'b0, sho_reg}) * sv[2] + $signed({1'b0, low_reg}) * sv[4];
        hc_a  <= $signed({1'b0, hip_reg}) * sv[1];
        hs_a  <= $signed({1'b0, hip_reg}) * sv[0];

        sa_b <= sa_a; ca_b <= ca_a; s2_b <= s2_a; c2_b <= c2_a;
        r00_b <= rq14(p00_a); r01_b <= rq14(p01_a);
        r10_b <= rq14(p10_a); r11_b <= rq14(p11_a);
        qx_b <= qx_a; qy_b <= qy_a; hc_b <= hc_a; hs_b <= hs_a;

        sa_c <= sa_b; ca_c <= ca_b; s2_c <= s2_b; c2_c <= c2_b;
        r00_c <= r00_b; r01_c <= r01_b; r10_c <= r10_b; r11_c <= r11_b;
        x1_c <= sa_b * qx_b;
        y1_c <= -(ca_b * qx_b);
        hc_c <= hc_b; hs_c <= hs_b; qy_c <= qy_b;

        sa_d <= sa_c; ca_d <= ca_c; s2_d <= s2_c; c2_d <= c2_c;
        r00_d <= r00_c; r01_d <= r01_c; r10_d <= r10_c; r11_d <= r11_c;
        // Position in Q36, rounded half up to Q8.
        x_d <= (54'(x1_c) - (54'(hc_c) <<< 14) + (54'sd1 <<< 27)) >>> 28;
        y_d <= (54'(y1_c) - (54'(hs_c) <<< 14) + (54'sd1 <<< 27)) >>> 28;
        qy_d <= (qy_c + 35'sd8192) >>> 14;
    end

    assign done   = vld_reg[LAT-1];
    assign rot_00 = r00_d;
    assign rot_01 = r01_d;
    assign rot_02 = 16'(-ca_d);
    assign rot_10 = r10_d;
    assign rot_11 = r11_d;
    assign rot_12 = 16'(-sa_d);
    assign rot_20 = s2_d[15:0];
    assign rot_21 = c2_d[15:0];
    assign rot_22 = '0;
    assign foot_x = satp(x_d);
    assign foot_y = satp(y_d);
    assign foot_z = satp(54'(qy_d));

    a_busy: assert property (@(posedge clk) !busy)
        else $error("busy raised");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("result lost");
    a_nodone: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !done)
        else $error("result after reset");
endmodule
`default_nettype wire

[tb/leg_forward_kinematics_test.sv]
// Self-checking testbench for leg_forward_kinematics: drives random and directed joint angles
// under several link-length settings and checks every foot transform against its own predictor.
// Depends on lfk_pkg and the RTL of leg_forward_kinematics.
`timescale 1ns / 100ps
module leg_forward_kinematics_test;
    import lfk_pkg::*;

    localparam int LATENCY     = 11;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [ADDR_BITS-1:0] ADDR_UNUSED = 4'd12;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] hip;
        logic [ANGLE_BITS-1:0] shoulder;
        logic [ANGLE_BITS-1:0] knee;
    } joint_angles_t;

    typedef struct {
        logic [ROT_BITS-1:0] rot [9];
        logic [POS_BITS-1:0] pos [3];
    } foot_pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    logic signed [ANGLE_BITS-1:0] hip_angle = '0;
    logic signed [ANGLE_BITS-1:0] shoulder_angle = '0;
    logic signed [ANGLE_BITS-1:0] knee_angle = '0;
    logic done;
    logic signed [ROT_BITS-1:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12;
    logic signed [ROT_BITS-1:0] rot_20, rot_21, rot_22;
    logic signed [POS_BITS-1:0] foot_x, foot_y, foot_z;

    joint_angles_t pending_legs[$];
    foot_pose_t    expected_poses[$];
    longint        link_len [3];
    int            cycle_count = 0;
    int            mismatches = 0;
    int            unexpected = 0;
    int            legs_sent = 0;
    int            poses_checked = 0;
    int            gap_left = 0;
    int            burst_left = 4;

    leg_forward_kinematics u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .hip_angle(hip_angle), .shoulder_angle(shoulder_angle), .knee_angle(knee_angle),
        .done(done),
        .rot_00(rot_00), .rot_01(rot_01), .rot_02(rot_02),
        .rot_10(rot_10), .rot_11(rot_11), .rot_12(rot_12),
        .rot_20(rot_20), .rot_21(rot_21), .rot_22(rot_22),
        .foot_x(foot_x), .foot_y(foot_y), .foot_z(foot_z)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Quarter-wave sine of t in Q22, Q14 result, by the truncating Horner chain.
    function automatic longint quarter_wave(longint unsigned t);
        longint unsigned t2, p, r;
        t2 = (t * t) >> 22;
        p = K9;
        p = K7 - ((p * t2) >> 22);
        p = K5 - ((p * t2) >> 22);
        p = K3 - ((p * t2) >> 22);
        p = K1 - ((p * t2) >> 22);
        r = (t * p + (64'd1 << 37)) >> 38;
        if (r > 16384)
            r = 16384;
        return longint'(r);
    endfunction

    function automatic longint sine_of(logic [PHASE_BITS-1:0] phase);
        logic [21:0] f;
        longint unsigned t;
        longint m;
        f = phase[21:0];
        t = phase[22] ? ((64'd1 << 22) - f) : f;
        m = quarter_wave(t);
        return phase[23] ? -m : m;
    endfunction

    function automatic longint cosine_of(logic [PHASE_BITS-1:0] phase);
        return sine_of(phase + (24'd1 << 22));
    endfunction

    function automatic longint round_shift(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic [POS_BITS-1:0] clamp_position(longint v);
        if (v < -196608)
            v = -196608;
        if (v > 196607)
            v = 196607;
        return v[POS_BITS-1:0];
    endfunction

    function automatic foot_pose_t predict_pose(joint_angles_t a);
        foot_pose_t fp;
        logic [ANGLE_BITS-1:0] bend;
        longint sa, ca, sb, cb, s2, c2, qx, qy, x36, y36;
        bend = a.shoulder + a.knee;
        sa = sine_of({a.hip, 8'd0});
        ca = cosine_of({a.hip, 8'd0});
        sb = sine_of({a.shoulder, 8'd0});
        cb = cosine_of({a.shoulder, 8'd0});
        s2 = sine_of({bend, 8'd0});
        c2 = cosine_of({bend, 8'd0});
        qx = link_len[1] * cb + link_len[2] * c2;
        qy = link_len[1] * sb + link_len[2] * s2;
        x36 = sa * qx - (link_len[0] * ca) * 16384;
        y36 = -(ca * qx) - (link_len[0] * sa) * 16384;
        fp.rot[0] = ROT_BITS'(round_shift(sa * c2, 14));
        fp.rot[1] = ROT_BITS'(round_shift(-(sa * s2), 14));
        fp.rot[2] = ROT_BITS'(-ca);
        fp.rot[3] = ROT_BITS'(round_shift(-(ca * c2), 14));
        fp.rot[4] = ROT_BITS'(round_shift(ca * s2, 14));
        fp.rot[5] = ROT_BITS'(-sa);
        fp.rot[6] = ROT_BITS'(s2);
        fp.rot[7] = ROT_BITS'(c2);
        fp.rot[8] = '0;
        fp.pos[0] = clamp_position(round_shift(x36, 28));
        fp.pos[1] = clamp_position(round_shift(y36, 28));
        fp.pos[2] = clamp_position(round_shift(qy, 14));
        return fp;
    endfunction

    // Sender: bursts of transfers separated by random gaps, sometimes none for a while.
    always @(negedge clk)
    begin
        if (rst_n && gap_left == 0 && pending_legs.size() != 0)
        begin
            start <= 1'b1;
            hip_angle <= pending_legs[0].hip;
            shoulder_angle <= pending_legs[0].shoulder;
            knee_angle <= pending_legs[0].knee;
            burst_left = burst_left - 1;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
            end
        end
        else
        begin
            start <= 1'b0;
            if (gap_left > 0)
                gap_left = gap_left - 1;
        end
    end

    // Accepts transfers into the prediction store and checks each strobed result.
    always @(posedge clk)
    begin
        foot_pose_t want;
        logic [ROT_BITS-1:0] got_rot [9];
        logic [POS_BITS-1:0] got_pos [3];
        bit bad;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
        else if (rst_n)
        begin
            if (done)
            begin
                got_rot = '{rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                            rot_20, rot_21, rot_22};
                got_pos = '{foot_x, foot_y, foot_z};
                if (expected_poses.size() == 0)
                begin
                    unexpected++;
                    $display("Result with no transfer outstanding at cycle %0d", cycle_count);
                end
                else
                begin
                    want = expected_poses.pop_front();
                    bad = 1'b0;
                    for (int i = 0; i < 9; i++)
                        if (got_rot[i] !== want.rot[i])
                            bad = 1'b1;
                    for (int i = 0; i < 3; i++)
                        if (got_pos[i] !== want.pos[i])
                            bad = 1'b1;
                    poses_checked++;
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            for (int i = 0; i < 9; i++)
                                $display("  rot[%0d] expected %0d got %0d", i,
                                         $signed(want.rot[i]), $signed(got_rot[i]));
                            for (int i = 0; i < 3; i++)
                                $display("  pos[%0d] expected %0d got %0d", i,
                                         $signed(want.pos[i]), $signed(got_pos[i]));
                            $display("Mismatch on result %0d", poses_checked);
                        end
                    end
                end
            end
            if (start && !busy && pending_legs.size() != 0)
            begin
                expected_poses.push_back(predict_pose(pending_legs.pop_front()));
                legs_sent++;
            end
        end
    end

    task automatic write_length(input logic [ADDR_BITS-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (addr)
            ADDR_HIP:      link_len[0] = data[LENGTH_BITS-1:0];
            ADDR_SHOULDER: link_len[1] = data[LENGTH_BITS-1:0];
            ADDR_LOWER:    link_len[2] = data[LENGTH_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_legs.size() != 0 || expected_poses.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_lengths(input logic [31:0] h, input logic [31:0] s,
                               input logic [31:0] l);
        write_length(ADDR_HIP, h);
        write_length(ADDR_SHOULDER, s);
        write_length(ADDR_LOWER, l);
    endtask

    task automatic add_leg(input int h, input int s, input int k);
        joint_angles_t a;
        a.hip = h[ANGLE_BITS-1:0];
        a.shoulder = s[ANGLE_BITS-1:0];
        a.knee = k[ANGLE_BITS-1:0];
        pending_legs.push_back(a);
    endtask

    initial
    begin
        link_len = '{0, 0, 0};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Lengths still at reset: pure rotation.
        add_leg(0, 0, 0);
        add_leg(16384, -16384, 32767);
        add_leg(-32768, -32768, -32768);
        wait_idle();

        // Longest links, for the largest positions; extremes of every angle.
        set_lengths(32'hFFFF_FFFF, 32'h0001_FFFF, 32'hABCD_FFFF);
        add_leg(0, 0, 0);
        add_leg(32767, 32767, 32767);
        add_leg(-32768, 0, 0);
        add_leg(16384, 16384, 16384);
        add_leg(-16384, -16384, -16384);
        add_leg(8192, -8192, 24576);
        add_leg(-1, -1, 1);
        add_leg(1, 32767, 1);
        add_leg(0, -32768, -32768);
        add_leg(0, 32767, -32767);
        add_leg(-32768, 16384, -16383);
        add_leg(4096, 12288, 20480);
        add_leg(0, 16384, 0);
        add_leg(0, -16384, 0);
        add_leg(16384, 0, 16384);
        add_leg(-16384, 0, -16384);
        add_leg(32767, -32768, 32767);
        add_leg(255, 256, -512);
        wait_idle();

        // Writes to an unused address leave the lengths alone.
        write_length(ADDR_UNUSED, 32'h0000_1234);
        add_leg(1000, 2000, 3000);

        for (int phase = 0; phase < 6; phase++)
        begin
            wait_idle();
            case (phase)
                0: set_lengths($urandom, $urandom, $urandom);
                1: set_lengths(0, 0, 0);
                2: set_lengths($urandom_range(0, 2048), $urandom_range(0, 8192),
                               $urandom_range(0, 8192));
                3: set_lengths(32'd65535, 32'd65535, 32'd65535);
                4: set_lengths($urandom_range(0, 65535), 0, $urandom_range(0, 65535));
                default: set_lengths($urandom, $urandom_range(0, 20000),
                                     $urandom_range(0, 20000));
            endcase
            for (int i = 0; i < 255; i++)
                add_leg($urandom, $urandom, $urandom);
        end

        wait_idle();
        $display("Checked %0d foot transforms from %0d legs over eight link-length settings,",
                 poses_checked, legs_sent);
        $display("with angle extremes, wrap-around and saturated positions included.");
        if (mismatches == 0 && unexpected == 0 && expected_poses.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
